// File: src/pcte_pkg.sv
// shared types, widths and codes for the piecewise cubic table evaluator
// no dependencies; every other file refers to this package by scoped names
package pcte_pkg;

    // table geometry and number format
    localparam int SEGMENTS  = 256;
    localparam int ADDR_W    = $clog2(SEGMENTS);
    localparam int SEG_CNT_W = 9;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int INV_W     = 31;
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 2;

    // datapath widths
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SEG_W  = PROD_W - 1 - 2 * FRAC_BITS;
    localparam int OP0_W  = DATA_W + 2;
    localparam int ACC_W  = DATA_W + 3;
    localparam int P1_W   = OP0_W + FRAC_BITS + 1;
    localparam int P2_W   = ACC_W + FRAC_BITS + 1;
    localparam int P3_W   = ACC_W + INV_W + 1;
    localparam int FIN_W  = P3_W - FRAC_BITS + 1;

    // reset values of the configuration registers
    localparam logic [DATA_W-1:0]    RESET_RANGE_START = '0;
    localparam logic [INV_W-1:0]     RESET_INV_WIDTH   = INV_W'(1 << FRAC_BITS);
    localparam logic [SEG_CNT_W-1:0] RESET_SEG_COUNT   = SEG_CNT_W'(SEGMENTS);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_DERIV = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_START = 2'd0,
        CFG_INV_WIDTH   = 2'd1,
        CFG_SEG_COUNT   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind                     kind;
        logic        [IDX_W-1:0]   entry_index;
        logic signed [DATA_W-1:0]  coef_cubic_in;
        logic signed [DATA_W-1:0]  coef_square_in;
        logic signed [DATA_W-1:0]  coef_linear_in;
        logic signed [DATA_W-1:0]  coef_const_in;
        logic signed [DATA_W-1:0]  x_value;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic                      clamped;
        logic                      saturated;
    } t_out_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0]  cubic;
        logic signed [DATA_W-1:0]  square;
        logic signed [DATA_W-1:0]  linear;
        logic signed [DATA_W-1:0]  offset;
    } t_coef_set;

    typedef struct packed {
        t_kind  kind;
        logic   clamped;
    } t_stage_ctl;

endpackage

// File: src/pcte_coef_mem.sv
// coefficient table: one entry of four cubic coefficients per segment
// one write port, one registered read port; uses pcte_pkg
module pcte_coef_mem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [pcte_pkg::ADDR_W-1:0] i_wr_addr,
    input  pcte_pkg::t_coef_set         i_wr_data,
    input  logic                        i_rd_en,
    input  logic [pcte_pkg::ADDR_W-1:0] i_rd_addr,
    output pcte_pkg::t_coef_set         o_rd_data
);

    pcte_pkg::t_coef_set r_mem [pcte_pkg::SEGMENTS];
    pcte_pkg::t_coef_set r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/piecewise_cubic_table_eval_core.sv
// top level of the piecewise cubic table evaluator: seven-stage pipeline
// depends on pcte_pkg and pcte_coef_mem
//
// one request enters per clock while the output side keeps taking
// responses, and responses leave in request order; each stage holds a
// valid bit and only advances into a free or draining slot, so bubbles are
// squeezed out while the output waits and no request is lost or repeated.
// a load request writes its four coefficients into the table when it reaches
// the table stage, in order with evaluations, and answers with zeros. an
// evaluation forms (x - range_start) * inverse_width, picks the segment from
// the integer part and t from the fraction, reads the coefficients, then
// runs the horner steps on one multiplier per stage; below range it returns
// segment 0's constant, above range the last segment's constant, the
// derivative is zero there and clamped is set. results saturate to 32 bits.
// the table has no reset; evaluating an unloaded segment gives undefined
// data. configuration writes take effect at once and are always accepted,
// so they belong to idle periods only
module piecewise_cubic_table_eval_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pcte_pkg::t_in_req               i_in_req,
    // response channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pcte_pkg::t_out_rsp              o_out_rsp,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcte_pkg::DATA_W-1:0]     i_cfg_data
);

    localparam int FB = pcte_pkg::FRAC_BITS;

    // configuration registers
    logic        [pcte_pkg::DATA_W-1:0]    r_range_start;
    logic        [pcte_pkg::INV_W-1:0]     r_inv_width;
    logic        [pcte_pkg::SEG_CNT_W-1:0] r_seg_count;

    // stage valid bits and advance enables (en[8] is the output handshake)
    logic [7:1] r_valid;
    logic [7:1] n_valid;
    logic [8:1] en;

    // stage 1: offset from range start
    pcte_pkg::t_kind                       r_kind1;
    logic signed [pcte_pkg::DIFF_W-1:0]    r_diff1;
    logic        [pcte_pkg::IDX_W-1:0]     r_idx1;
    pcte_pkg::t_coef_set                   r_coef1;

    // stage 2: local coordinate
    logic signed [pcte_pkg::DIFF_W+pcte_pkg::INV_W:0] n_prod2;
    pcte_pkg::t_kind                       r_kind2;
    logic signed [pcte_pkg::PROD_W-1:0]    r_prod2;
    logic        [pcte_pkg::IDX_W-1:0]     r_idx2;
    pcte_pkg::t_coef_set                   r_coef2;

    // stage 3: table access
    logic                                  n_below;
    logic                                  n_above;
    logic        [pcte_pkg::SEG_W-1:0]     n_seg;
    logic        [pcte_pkg::SEG_CNT_W-1:0] n_seg_eff;
    logic        [pcte_pkg::SEG_CNT_W-1:0] n_seg_last;
    logic        [pcte_pkg::ADDR_W-1:0]    n_rd_addr;
    logic                                  n_wr_en;
    pcte_pkg::t_coef_set                   mem_q;
    pcte_pkg::t_stage_ctl                  r_ctl3;
    logic        [FB-1:0]                  r_t3;

    // stage 4: first product
    logic signed [pcte_pkg::OP0_W-1:0]     n_op0;
    logic signed [pcte_pkg::ACC_W-1:0]     n_add1;
    pcte_pkg::t_stage_ctl                  r_ctl4;
    logic        [FB-1:0]                  r_t4;
    logic signed [pcte_pkg::P1_W-1:0]      r_p4;
    logic signed [pcte_pkg::ACC_W-1:0]     r_add4;
    logic signed [pcte_pkg::DATA_W-1:0]    r_lin4;
    logic signed [pcte_pkg::DATA_W-1:0]    r_off4;

    // stage 5: second product
    logic signed [pcte_pkg::ACC_W-1:0]     n_acc1;
    pcte_pkg::t_stage_ctl                  r_ctl5;
    logic        [FB-1:0]                  r_t5;
    logic signed [pcte_pkg::P2_W-1:0]      r_p5;
    logic signed [pcte_pkg::DATA_W-1:0]    r_lin5;
    logic signed [pcte_pkg::DATA_W-1:0]    r_off5;

    // stage 6: third product, by t for the value or by inverse width
    logic signed [pcte_pkg::ACC_W-1:0]     n_acc2;
    logic        [pcte_pkg::INV_W-1:0]     n_mul3;
    pcte_pkg::t_stage_ctl                  r_ctl6;
    logic signed [pcte_pkg::P3_W-1:0]      r_p6;
    logic signed [pcte_pkg::DATA_W-1:0]    r_off6;

    // stage 7: final add, saturation, output register
    logic signed [pcte_pkg::FIN_W-1:0]     n_fin;
    logic        [pcte_pkg::FIN_W-pcte_pkg::DATA_W:0] n_fin_hi;
    pcte_pkg::t_out_rsp                    n_rsp;
    pcte_pkg::t_out_rsp                    r_rsp7;

    //--------------------------------------------------------------------
    // configuration port, never stalls
    //--------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= pcte_pkg::RESET_RANGE_START;
            r_inv_width   <= pcte_pkg::RESET_INV_WIDTH;
            r_seg_count   <= pcte_pkg::RESET_SEG_COUNT;
        end else if (i_cfg_valid) begin
            case (pcte_pkg::t_cfg_index'(i_cfg_index))
                pcte_pkg::CFG_RANGE_START: r_range_start <= i_cfg_data;
                pcte_pkg::CFG_INV_WIDTH:   r_inv_width   <= i_cfg_data[pcte_pkg::INV_W-1:0];
                pcte_pkg::CFG_SEG_COUNT:   r_seg_count   <= i_cfg_data[pcte_pkg::SEG_CNT_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    //--------------------------------------------------------------------
    // pipeline flow control: a stage moves when it is empty or its
    // successor moves
    //--------------------------------------------------------------------
    always_comb begin
        en[8] = i_out_ready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = r_valid;
        if (en[1]) begin
            n_valid[1] = i_in_valid;
        end
        for (int k = 2; k <= 7; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_valid[7];
    assign o_out_rsp   = r_rsp7;

    //--------------------------------------------------------------------
    // stage 1: x - range_start
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_kind1        <= i_in_req.kind;
            r_diff1        <= pcte_pkg::DIFF_W'(i_in_req.x_value)
                            - pcte_pkg::DIFF_W'($signed(r_range_start));
            r_idx1         <= i_in_req.entry_index;
            r_coef1.cubic  <= i_in_req.coef_cubic_in;
            r_coef1.square <= i_in_req.coef_square_in;
            r_coef1.linear <= i_in_req.coef_linear_in;
            r_coef1.offset <= i_in_req.coef_const_in;
        end
    end

    //--------------------------------------------------------------------
    // stage 2: scale by inverse width, never negative zero issues since the
    // product stays below 2^63 in magnitude
    //--------------------------------------------------------------------
    assign n_prod2 = r_diff1 * $signed({1'b0, r_inv_width});

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_kind2 <= r_kind1;
            r_prod2 <= n_prod2[pcte_pkg::PROD_W-1:0];
            r_idx2  <= r_idx1;
            r_coef2 <= r_coef1;
        end
    end

    //--------------------------------------------------------------------
    // stage 3: segment select, range clamp, table read and load write
    //--------------------------------------------------------------------
    always_comb begin
        n_below = r_prod2[pcte_pkg::PROD_W-1];
        n_seg   = r_prod2[pcte_pkg::PROD_W-2:2*FB];
        if (r_seg_count == '0) begin
            n_seg_eff = pcte_pkg::SEG_CNT_W'(1);
        end else if (r_seg_count > pcte_pkg::SEG_CNT_W'(pcte_pkg::SEGMENTS)) begin
            n_seg_eff = pcte_pkg::SEG_CNT_W'(pcte_pkg::SEGMENTS);
        end else begin
            n_seg_eff = r_seg_count;
        end
        n_seg_last = n_seg_eff - pcte_pkg::SEG_CNT_W'(1);
        n_above    = !n_below && (n_seg >= pcte_pkg::SEG_W'(n_seg_eff));
        if (n_below) begin
            n_rd_addr = '0;
        end else if (n_above) begin
            n_rd_addr = n_seg_last[pcte_pkg::ADDR_W-1:0];
        end else begin
            n_rd_addr = n_seg[pcte_pkg::ADDR_W-1:0];
        end
        // loads retire into the table here, in order with evaluations
        n_wr_en = en[3] && r_valid[2] && (r_kind2 == pcte_pkg::KIND_LOAD)
               && ({1'b0, r_idx2} < (pcte_pkg::IDX_W+1)'(pcte_pkg::SEGMENTS));
    end

    pcte_coef_mem u_coef_mem (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (r_idx2[pcte_pkg::ADDR_W-1:0]),
        .i_wr_data (r_coef2),
        .i_rd_en   (en[3]),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_ctl3.kind    <= r_kind2;
            r_ctl3.clamped <= n_below || n_above;
            r_t3           <= r_prod2[2*FB-1:FB];
        end
    end

    //--------------------------------------------------------------------
    // stage 4: a*t for the value, 3a*t for the derivative
    //--------------------------------------------------------------------
    always_comb begin
        if (r_ctl3.kind == pcte_pkg::KIND_DERIV) begin
            n_op0  = pcte_pkg::OP0_W'(mem_q.cubic)
                   + (pcte_pkg::OP0_W'(mem_q.cubic) <<< 1);
            n_add1 = pcte_pkg::ACC_W'(mem_q.square) <<< 1;
        end else begin
            n_op0  = pcte_pkg::OP0_W'(mem_q.cubic);
            n_add1 = pcte_pkg::ACC_W'(mem_q.square);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_ctl4 <= r_ctl3;
            r_t4   <= r_t3;
            r_p4   <= n_op0 * $signed({1'b0, r_t3});
            r_add4 <= n_add1;
            r_lin4 <= mem_q.linear;
            r_off4 <= mem_q.offset;
        end
    end

    //--------------------------------------------------------------------
    // stage 5: floor shift, add b (or 2b), multiply by t
    //--------------------------------------------------------------------
    assign n_acc1 = r_p4[FB+pcte_pkg::ACC_W-1:FB] + r_add4;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_ctl5 <= r_ctl4;
            r_t5   <= r_t4;
            r_p5   <= n_acc1 * $signed({1'b0, r_t4});
            r_lin5 <= r_lin4;
            r_off5 <= r_off4;
        end
    end

    //--------------------------------------------------------------------
    // stage 6: add c, then multiply by t or by the inverse width
    //--------------------------------------------------------------------
    always_comb begin
        n_acc2 = r_p5[FB+pcte_pkg::ACC_W-1:FB] + pcte_pkg::ACC_W'(r_lin5);
        if (r_ctl5.kind == pcte_pkg::KIND_VALUE) begin
            n_mul3 = pcte_pkg::INV_W'(r_t5);
        end else begin
            n_mul3 = r_inv_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_ctl6 <= r_ctl5;
            r_p6   <= n_acc2 * $signed({1'b0, n_mul3});
            r_off6 <= r_off5;
        end
    end

    //--------------------------------------------------------------------
    // stage 7: add d for the value, saturate, special cases
    //--------------------------------------------------------------------
    always_comb begin
        // floor shift keeps the sign of the product
        n_fin = pcte_pkg::FIN_W'($signed(r_p6[pcte_pkg::P3_W-1:FB]));
        if (r_ctl6.kind == pcte_pkg::KIND_VALUE) begin
            n_fin = n_fin + pcte_pkg::FIN_W'(r_off6);
        end
        n_fin_hi = n_fin[pcte_pkg::FIN_W-1:pcte_pkg::DATA_W-1];
        n_rsp    = '0;
        case (r_ctl6.kind)
            pcte_pkg::KIND_VALUE, pcte_pkg::KIND_DERIV: begin
                if (r_ctl6.clamped) begin
                    // out of range: edge constant for the value, zero slope
                    n_rsp.clamped = 1'b1;
                    if (r_ctl6.kind == pcte_pkg::KIND_VALUE) begin
                        n_rsp.result_value = r_off6;
                    end
                end else if (n_fin_hi != '0 && n_fin_hi != '1) begin
                    n_rsp.saturated    = 1'b1;
                    n_rsp.result_value = n_fin[pcte_pkg::FIN_W-1]
                                       ? {1'b1, {(pcte_pkg::DATA_W-1){1'b0}}}
                                       : {1'b0, {(pcte_pkg::DATA_W-1){1'b1}}};
                end else begin
                    n_rsp.result_value = n_fin[pcte_pkg::DATA_W-1:0];
                end
            end
            default: ;  // load or unknown kind answers with zeros
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_rsp7 <= n_rsp;
        end
    end

endmodule

// File: src/pcte_checker.sv
// port-level checks for piecewise_cubic_table_eval_core, bound to the top level
// depends on pcte_pkg for the payload types
module pcte_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  pcte_pkg::t_in_req               i_in_req,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  pcte_pkg::t_out_rsp              o_out_rsp,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [pcte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcte_pkg::DATA_W-1:0]     i_cfg_data
);

    // a held response stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("response withdrawn before it was taken");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response offered right after reset");

    // an empty output means the pipeline can always take a request
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while the output stage is empty");

    // a clamped result is an edge constant or zero, never saturated
    a_clamp_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.clamped |-> !o_out_rsp.saturated)
        else $error("clamped response flagged as saturated");

endmodule

bind piecewise_cubic_table_eval_core pcte_checker u_pcte_checker (.*);
